FILE: hw/rtl/angle_wrapped_position_pid_core_defines.svh
// Assertion macros shared by the angle-wrapped position PID RTL.
// Each file that asserts includes this header; it needs clk and rst_n in scope.
`ifndef ANGLE_WRAPPED_POSITION_PID_CORE_DEFINES_SVH
`define ANGLE_WRAPPED_POSITION_PID_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define AWPID_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("awpid same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define AWPID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("awpid next-cycle check failed");

`endif

FILE: hw/rtl/awpid_pkg.sv
// Package for the angle-wrapped position PID core: field widths, constants,
// register indexes and the beat structs passed between pipeline stages.
// No dependencies.
package awpid_pkg;

    // Field and datapath widths
    localparam int POS_W      = 15;
    localparam int GAIN_W     = 24;
    localparam int LIM_W      = 15;
    localparam int ERR_W      = 16;
    localparam int DIFF_W     = 17;
    localparam int INTEG_W    = 32;
    localparam int OUT_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int P_TERM_W   = GAIN_W + ERR_W;
    localparam int D_TERM_W   = GAIN_W + DIFF_W;
    localparam int I_TERM_W   = GAIN_W + INTEG_W;
    localparam int SUM_W      = I_TERM_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Angle constants in 1/64 degree
    localparam logic signed [DIFF_W-1:0] HALF_TURN = 17'sd11520;
    localparam logic signed [DIFF_W-1:0] FULL_TURN = 17'sd23040;

    // Register reset values
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST    = 24'sd5243;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST   = 24'sd0;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST   = 24'sd5243;
    localparam logic [LIM_W-1:0]         OUTPUT_LIMIT_RST = 15'd6400;
    localparam logic signed [POS_W-1:0]  TARGET_POS_RST   = 15'sd0;
    localparam logic                     LOOP_ENABLE_RST  = 1'b0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN       = 3'd0,
        REG_INTEG_GAIN      = 3'd1,
        REG_DERIV_GAIN      = 3'd2,
        REG_OUTPUT_LIMIT    = 3'd3,
        REG_TARGET_POSITION = 3'd4,
        REG_LOOP_ENABLE     = 3'd5
    } reg_index_t;

    // Current configuration as seen by the datapath
    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [LIM_W-1:0]         output_limit;
        logic signed [POS_W-1:0]  target_position;
        logic                     loop_enable;
    } cfg_t;

    // Error stage to multiplier stage
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DIFF_W-1:0]  diff;
        logic signed [INTEG_W-1:0] integ;
    } err_beat_t;

    // Multiplier stage to output stage
    typedef struct packed {
        logic signed [P_TERM_W-1:0] p_term;
        logic signed [D_TERM_W-1:0] d_term;
        logic signed [I_TERM_W-1:0] i_term;
    } prod_beat_t;

endpackage

FILE: hw/rtl/angle_wrapped_position_pid_core.sv
// Angle-wrapped positional PID controller with Q8.16 gains and output clamp.
// Top level; depends on awpid_pkg, awpid_cfg, awpid_err, awpid_mul, awpid_out.
//
// Usage:
//   Each beat on the slave stream (s_tvalid, s_tready, s_tdata) is one control
//   tick carrying the measured angle. Each tick gives exactly one beat on the
//   master stream (m_tvalid, m_tready, m_tdata) with the speed command.
//   Configuration registers are written on the cfg channel (cfg_valid,
//   cfg_ready, cfg_index, cfg_data); cfg_ready is always high.
//   Write registers only while no tick is in flight.
//   A tick passes through five pipeline registers in order: input, error,
//   products, sum, result. Throughput: one tick per cycle while the
//   receiver keeps m_tready high; the error stage updates the previous
//   error and integral once for each tick that moves on.
//   When the receiver stalls, the result register holds its beat and the
//   earlier stages keep filling until all five hold a tick; s_tready then
//   falls until m_tready returns.
//   Reset clears all valid flags, the previous error and the integral, and
//   loads the register defaults; the loop starts disabled (output zero).
module angle_wrapped_position_pid_core
    import awpid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Slave stream: [14:0] measured_position, [15] zero pad
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,
    // Master stream: [15:0] speed_command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                    cfg;
    logic                    err_valid;
    logic                    err_ready;
    err_beat_t               err_beat;
    logic                    prod_valid;
    logic                    prod_ready;
    prod_beat_t              prod_beat;
    logic signed [OUT_W-1:0] speed_command;

    // Configuration registers.
    awpid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register, wrap and state update.
    awpid_err u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pos    ($signed(s_tdata[POS_W-1:0])),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_beat  (err_beat)
    );

    // Gain products.
    awpid_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_beat   (err_beat),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_beat  (prod_beat)
    );

    // Sum, clamp, round and output register.
    awpid_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_beat   (prod_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (speed_command)
    );

    assign m_tdata = speed_command;

endmodule

FILE: hw/rtl/awpid_cfg.sv
// Configuration register file of the angle-wrapped position PID core.
// Depends on awpid_pkg.
module awpid_cfg
    import awpid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Writes are always accepted.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= PROP_GAIN_RST;
            cfg_reg.integ_gain      <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain      <= DERIV_GAIN_RST;
            cfg_reg.output_limit    <= OUTPUT_LIMIT_RST;
            cfg_reg.target_position <= TARGET_POS_RST;
            cfg_reg.loop_enable     <= LOOP_ENABLE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_PROP_GAIN:       cfg_reg.prop_gain       <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:      cfg_reg.integ_gain      <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:      cfg_reg.deriv_gain      <= cfg_data[GAIN_W-1:0];
                REG_OUTPUT_LIMIT:    cfg_reg.output_limit    <= cfg_data[LIM_W-1:0];
                REG_TARGET_POSITION: cfg_reg.target_position <= cfg_data[POS_W-1:0];
                REG_LOOP_ENABLE:     cfg_reg.loop_enable     <= cfg_data[0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

endmodule

FILE: hw/rtl/awpid_err.sv
// Input register, angle wrap, error forming and controller state update.
// Depends on awpid_pkg and angle_wrapped_position_pid_core_defines.svh.
`include "angle_wrapped_position_pid_core_defines.svh"
module awpid_err
    import awpid_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [POS_W-1:0] in_pos,
    output logic                    out_valid,
    input  logic                    out_ready,
    output err_beat_t               out_beat
);

    logic                      in_valid_reg;
    logic signed [POS_W-1:0]   pos_reg;
    logic                      beat_valid_reg;
    err_beat_t                 beat_reg;
    logic signed [ERR_W-1:0]   prev_error_reg;
    logic signed [INTEG_W-1:0] integ_reg;

    logic signed [DIFF_W-1:0]  diff_raw;
    logic signed [DIFF_W-1:0]  diff_wrapped;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_next;
    logic                      beat_ready;
    logic                      move;

    // Stage handshake: a stage loads when empty or when its beat moves on.
    assign beat_ready = !beat_valid_reg || out_ready;
    assign in_ready   = !in_valid_reg || beat_ready;
    assign move       = in_valid_reg && beat_ready;
    assign out_valid  = beat_valid_reg;
    assign out_beat   = beat_reg;

    // Measured minus target, wrapped once into half a turn, then negated.
    always_comb
    begin
        diff_raw = DIFF_W'(pos_reg) - DIFF_W'(cfg.target_position);
        priority if (diff_raw > HALF_TURN)
            diff_wrapped = diff_raw - FULL_TURN;
        else if (diff_raw < -HALF_TURN)
            diff_wrapped = diff_raw + FULL_TURN;
        else
            diff_wrapped = diff_raw;
        err_next  = ERR_W'(-diff_wrapped);
        diff_next = DIFF_W'(err_next) - DIFF_W'(prev_error_reg);
    end

    // Saturating integral update.
    always_comb
    begin
        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err_next);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
            integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        else
            integ_next = integ_sum[INTEG_W-1:0];
    end

    // Valid flags and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            beat_valid_reg <= 1'b0;
            prev_error_reg <= '0;
            integ_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (beat_ready)
                beat_valid_reg <= in_valid_reg;
            if (move)
            begin
                prev_error_reg <= err_next;
                integ_reg      <= integ_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            pos_reg <= in_pos;
        if (move)
        begin
            beat_reg.err   <= err_next;
            beat_reg.diff  <= diff_next;
            beat_reg.integ <= integ_reg;
        end
    end

    // The stored previous error is the error just handed downstream.
    `AWPID_ASSERT_NEXT(a_prev_err_tracks, move, prev_error_reg == beat_reg.err)
    // A non-negative integral never wraps negative on a non-negative error.
    `AWPID_ASSERT_NEXT(a_integ_no_wrap_up, move && !integ_reg[INTEG_W-1] && !err_next[ERR_W-1], !integ_reg[INTEG_W-1])
    // The difference term matches the error change carried with it.
    `AWPID_ASSERT_NEXT(a_diff_consistent, move, beat_reg.diff == DIFF_W'(beat_reg.err) - DIFF_W'($past(prev_error_reg)))

endmodule

FILE: hw/rtl/awpid_mul.sv
// Multiplier stage: the three gain products, registered.
// Depends on awpid_pkg.
module awpid_mul
    import awpid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  err_beat_t  in_beat,
    output logic       out_valid,
    input  logic       out_ready,
    output prod_beat_t out_beat
);

    logic       valid_reg;
    prod_beat_t prod_reg;
    prod_beat_t prod_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = prod_reg;

    // Products in Q.16 of output units.
    always_comb
    begin
        prod_next.p_term = P_TERM_W'(in_beat.err) * P_TERM_W'(cfg.prop_gain);
        prod_next.d_term = D_TERM_W'(in_beat.diff) * D_TERM_W'(cfg.deriv_gain);
        prod_next.i_term = I_TERM_W'(in_beat.integ) * I_TERM_W'(cfg.integ_gain);
    end

    // Stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Product registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            prod_reg <= prod_next;
    end

endmodule

FILE: hw/rtl/awpid_out.sv
// Sum stage and output stage: adds the terms, clamps, rounds and holds the result.
// Depends on awpid_pkg and angle_wrapped_position_pid_core_defines.svh.
`include "angle_wrapped_position_pid_core_defines.svh"
module awpid_out
    import awpid_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  prod_beat_t              in_beat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] out_data
);

    logic                    sum_valid_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    res_valid_reg;
    logic signed [OUT_W-1:0] res_reg;

    logic                    res_ready;
    logic                    load;
    logic signed [SUM_W-1:0] lim_wide;
    logic signed [SUM_W-1:0] rounded;
    logic signed [OUT_W-1:0] lim16;
    logic signed [OUT_W-1:0] res_next;

    assign res_ready = !res_valid_reg || out_ready;
    assign in_ready  = !sum_valid_reg || res_ready;
    assign load      = sum_valid_reg && res_ready;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // Zero while the loop is disabled; else clamp to the limit, otherwise round half up to whole units.
    always_comb
    begin
        lim_wide = $signed({{(SUM_W-LIM_W-FRAC_W){1'b0}}, cfg.output_limit, {FRAC_W{1'b0}}});
        lim16    = $signed({{(OUT_W-LIM_W){1'b0}}, cfg.output_limit});
        rounded  = sum_reg + $signed(SUM_W'(1) <<< (FRAC_W-1));
        priority if (!cfg.loop_enable)
            res_next = '0;
        else if (sum_reg > lim_wide)
            res_next = lim16;
        else if (sum_reg < -lim_wide)
            res_next = -lim16;
        else
            res_next = rounded[FRAC_W+OUT_W-1:FRAC_W];
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                sum_valid_reg <= in_valid;
            if (res_ready)
                res_valid_reg <= sum_valid_reg;
        end
    end

    // Sum and result registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            sum_reg <= SUM_W'(in_beat.p_term) + SUM_W'(in_beat.d_term)
                       + SUM_W'(in_beat.i_term);
        if (load)
            res_reg <= res_next;
    end

    // A loaded result always lies within the symmetric limit.
    `AWPID_ASSERT_IMPL(a_res_in_limit, load, res_next <= lim16 && res_next >= -lim16)
    // With the loop disabled every loaded result is zero.
    `AWPID_ASSERT_IMPL(a_res_disabled_zero, load && !cfg.loop_enable, res_next == '0)
    // A result that was loaded is on the output in the next cycle.
    `AWPID_ASSERT_NEXT(a_res_presented, load, out_valid)

endmodule
